/* src/fa_lru_pkg.sv */
package fa_lru_pkg;

	localparam int NUM_FRAMES_DEF = 32;

	localparam int OP_W    = 3;
	localparam int IDX_W   = 5;
	localparam int PID_W   = 8;
	localparam int STAMP_W = 31;
	localparam int FCNT_W  = 6;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_ALLOC = 3'd0;
	localparam op_t OP_FORCE = 3'd1;
	localparam op_t OP_FREE  = 3'd2;
	localparam op_t OP_TEST  = 3'd3;
	localparam op_t OP_TOUCH = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FREE_SCAN,
		ST_STAMP_SCAN,
		ST_STAMP_LAST,
		ST_OWNER_RD,
		ST_COMMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture request beat
		logic step;      // advance scan counter
		logic take_cnt;  // scan counter is the chosen frame
		logic stamp_rd;  // read stamp at scan counter
		logic owner_rd;  // read owner of chosen frame
		logic commit;    // update state, load response register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic none_free;
		logic cur_free;
		logic scan_last;
		logic out_busy;
	} status_t;

endpackage

/* src/fa_lru_req_if.sv */
interface fa_lru_req_if import fa_lru_pkg::*;;
	logic               valid;
	logic               ready;
	op_t                op;
	logic [IDX_W-1:0]   frame_index;
	logic [PID_W-1:0]   process_id;
	logic [STAMP_W-1:0] stamp;

	modport source (output valid, op, frame_index, process_id, stamp, input ready);
	modport sink   (input valid, op, frame_index, process_id, stamp, output ready);
endinterface

/* src/fa_lru_rsp_if.sv */
interface fa_lru_rsp_if import fa_lru_pkg::*;;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  granted_frame;
	logic              ok;
	logic              evicted;
	logic [PID_W-1:0]  evicted_owner;
	logic              is_used;
	logic [FCNT_W-1:0] free_count;

	modport source (output valid, granted_frame, ok, evicted, evicted_owner, is_used,
		free_count, input ready);
	modport sink   (input valid, granted_frame, ok, evicted, evicted_owner, is_used,
		free_count, output ready);
endinterface

/* src/fa_lru_dp.sv */
module fa_lru_dp import fa_lru_pkg::*; #(
	parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            sts,
	input  op_t                req_op,
	input  logic [IDX_W-1:0]   req_frame_index,
	input  logic [PID_W-1:0]   req_process_id,
	input  logic [STAMP_W-1:0] req_stamp,
	input  logic               rsp_ready,
	output logic               rsp_valid,
	output logic [IDX_W-1:0]   rsp_granted_frame,
	output logic               rsp_ok,
	output logic               rsp_evicted,
	output logic [PID_W-1:0]   rsp_evicted_owner,
	output logic               rsp_is_used,
	output logic [FCNT_W-1:0]  rsp_free_count
);

	localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int FW = $clog2(NUM_FRAMES + 1);

	// captured request
	op_t                op_q;
	logic [IDX_W-1:0]   idx_q;
	logic [PID_W-1:0]   pid_q;
	logic [STAMP_W-1:0] stamp_q;

	logic               used_q [NUM_FRAMES];
	logic [FW-1:0]      free_q;

	// owner and stamp are only read for used frames, all of which were written
	logic [PID_W-1:0]   owner_mem [NUM_FRAMES];
	logic [STAMP_W-1:0] stamp_mem [NUM_FRAMES];

	logic [IW-1:0]      cnt_q;
	logic [IW-1:0]      best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic               rd_vld_s1;
	logic               rd_first_s1;
	logic [IW-1:0]      rd_idx_s1;
	logic [STAMP_W-1:0] stamp_rd_s1;
	logic [PID_W-1:0]   owner_rd_q;

	logic               rsp_valid_q;
	logic [IDX_W-1:0]   grant_q;
	logic               ok_q;
	logic               ev_q;
	logic [PID_W-1:0]   ev_own_q;
	logic               used_res_q;
	logic [FCNT_W-1:0]  fcnt_q;

	logic [IW-1:0]      idx_n;
	logic               idx_ok;
	logic               none_free;

	logic               c_ok, c_ev, c_used;
	logic [PID_W-1:0]   c_own;
	logic [FW-1:0]      free_nxt;
	logic               set_used, clr_used, own_we, st_we;
	logic [IW-1:0]      st_waddr;

	assign idx_n     = IW'(idx_q);
	assign idx_ok    = 32'(idx_q) < 32'(NUM_FRAMES);
	assign none_free = (free_q == '0);

	assign sts.op        = op_q;
	assign sts.none_free = none_free;
	assign sts.cur_free  = !used_q[cnt_q];
	assign sts.scan_last = (cnt_q == IW'(NUM_FRAMES - 1));
	assign sts.out_busy  = rsp_valid_q && !rsp_ready;

	always_comb begin
		c_ok     = 1'b0;
		c_ev     = 1'b0;
		c_used   = 1'b0;
		c_own    = '0;
		free_nxt = free_q;
		set_used = 1'b0;
		clr_used = 1'b0;
		own_we   = 1'b0;
		st_we    = 1'b0;
		st_waddr = best_idx_q;
		case (op_q)
			OP_ALLOC, OP_FORCE: begin
				if (!none_free || op_q == OP_FORCE) begin
					c_ok     = 1'b1;
					set_used = 1'b1;
					own_we   = 1'b1;
					st_we    = 1'b1;
					if (none_free) begin
						c_ev  = 1'b1;
						c_own = owner_rd_q;
					end else begin
						free_nxt = free_q - 1'b1;
					end
				end
			end
			OP_FREE: begin
				if (idx_ok) begin
					c_ok     = 1'b1;
					clr_used = 1'b1;
					if (used_q[idx_n]) begin
						free_nxt = free_q + 1'b1;
					end
				end
			end
			OP_TEST: begin
				if (idx_ok) begin
					c_ok   = 1'b1;
					c_used = used_q[idx_n];
				end
			end
			OP_TOUCH: begin
				if (idx_ok) begin
					c_ok     = 1'b1;
					st_we    = 1'b1;
					st_waddr = idx_n;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= req_op;
			idx_q   <= req_frame_index;
			pid_q   <= req_process_id;
			stamp_q <= req_stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FRAMES; i++) begin
				used_q[i] <= 1'b0;
			end
			free_q <= FW'(NUM_FRAMES);
		end else if (cmd.commit) begin
			if (set_used) begin
				used_q[best_idx_q] <= 1'b1;
			end
			if (clr_used) begin
				used_q[idx_n] <= 1'b0;
			end
			free_q <= free_nxt;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.commit && st_we) begin
			stamp_mem[st_waddr] <= stamp_q;
		end
		if (cmd.stamp_rd) begin
			stamp_rd_s1 <= stamp_mem[cnt_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && own_we) begin
			owner_mem[best_idx_q] <= pid_q;
		end
		if (cmd.owner_rd) begin
			owner_rd_q <= owner_mem[best_idx_q];
		end
	end

	// scan counter and running minimum; strict compare keeps lowest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			rd_vld_s1 <= cmd.stamp_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.stamp_rd) begin
			rd_idx_s1   <= cnt_q;
			rd_first_s1 <= (cnt_q == '0);
		end
		if (cmd.take_cnt) begin
			best_idx_q <= cnt_q;
		end else if (rd_vld_s1 && (rd_first_s1 || stamp_rd_s1 < best_stamp_q)) begin
			best_idx_q   <= rd_idx_s1;
			best_stamp_q <= stamp_rd_s1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			grant_q    <= c_ok && (op_q == OP_ALLOC || op_q == OP_FORCE) ?
				IDX_W'(best_idx_q) : '0;
			ok_q       <= c_ok;
			ev_q       <= c_ev;
			ev_own_q   <= c_own;
			used_res_q <= c_used;
			fcnt_q     <= FCNT_W'(free_nxt);
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign rsp_granted_frame = grant_q;
	assign rsp_ok            = ok_q;
	assign rsp_evicted       = ev_q;
	assign rsp_evicted_owner = ev_own_q;
	assign rsp_is_used       = used_res_q;
	assign rsp_free_count    = fcnt_q;

endmodule

/* src/fa_lru_ctrl.sv */
module fa_lru_ctrl import fa_lru_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.op inside {OP_ALLOC, OP_FORCE}) begin
					if (!sts.none_free) begin
						state_nxt = ST_FREE_SCAN;
					end else if (sts.op == OP_FORCE) begin
						state_nxt = ST_STAMP_SCAN;
					end else begin
						state_nxt = ST_COMMIT;
					end
				end else begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_FREE_SCAN: begin
				if (sts.cur_free) begin
					cmd.take_cnt = 1'b1;
					state_nxt    = ST_COMMIT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_STAMP_SCAN: begin
				cmd.stamp_rd = 1'b1;
				cmd.step     = 1'b1;
				if (sts.scan_last) begin
					state_nxt = ST_STAMP_LAST;
				end
			end
			ST_STAMP_LAST: begin
				state_nxt = ST_OWNER_RD;
			end
			ST_OWNER_RD: begin
				cmd.owner_rd = 1'b1;
				state_nxt    = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

/* src/frame_allocator_lru_victim_top.sv */
// Sequencing: free, test, touch and failed allocate go from DECODE straight to COMMIT.
//   Allocate, and forced allocate with a free frame, scan from frame 0 in FREE_SCAN
//   up to the lowest free frame before COMMIT.
// Forced allocate with every frame used scans all NUM_FRAMES stamps in STAMP_SCAN,
//   one frame per cycle, then passes STAMP_LAST and OWNER_RD before COMMIT.
// Throughput: one request at a time; the next is taken the cycle after the response loads.
// Reset (arst_n low, asynchronous): every frame free, free count = NUM_FRAMES, no response.
module frame_allocator_lru_victim_top import fa_lru_pkg::*; #(
	parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	fa_lru_req_if.sink   req,
	fa_lru_rsp_if.source rsp
);

	// Controller sequences each request (free, test, touch and failed allocate skip the bracket):
	//   IDLE -> DECODE -> (FREE_SCAN | STAMP_SCAN -> STAMP_LAST -> OWNER_RD) -> COMMIT
	// The datapath holds the used bitmap, the free counter, owner and stamp
	// memories, the scan counter and the running minimum of the stamp scan.
	cmd_t    cmd;
	status_t sts;

	fa_lru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The response register is in the datapath; COMMIT waits while it still
	// holds an untaken beat, so no result is ever overwritten.
	fa_lru_dp #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.req_op            (req.op),
		.req_frame_index   (req.frame_index),
		.req_process_id    (req.process_id),
		.req_stamp         (req.stamp),
		.rsp_ready         (rsp.ready),
		.rsp_valid         (rsp.valid),
		.rsp_granted_frame (rsp.granted_frame),
		.rsp_ok            (rsp.ok),
		.rsp_evicted       (rsp.evicted),
		.rsp_evicted_owner (rsp.evicted_owner),
		.rsp_is_used       (rsp.is_used),
		.rsp_free_count    (rsp.free_count)
	);

	// A result only loads when the response slot is free.
	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !sts.out_busy)
		else $error("response loaded over an untaken beat");

	// No request is accepted while one is being finished.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> !cmd.commit && !cmd.step && !cmd.stamp_rd)
		else $error("request accepted while busy");

	// An eviction only happens when no frame was free, and always succeeds.
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.evicted) |-> (rsp.ok && rsp.free_count == '0))
		else $error("eviction with a free frame left");

	// A response beat appears only after a commit.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.commit))
		else $error("response without commit");

endmodule
